// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the queue core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define REEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define REEQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/reeq_pkg.sv =====
// ----------------------------------------------------------------------------
// reeq_pkg
// Types and constants of the rotary encoder event queue.
// ----------------------------------------------------------------------------
package reeq_pkg;

  localparam int NUM_ENCODERS = 5;
  localparam int QUEUE_DEPTH  = 16;

  localparam int PIN_W      = 5;
  localparam int IDX_W      = 3;
  localparam int DEBOUNCE_W = 16;
  localparam int IN_USE_W   = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int ENC_W  = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
  localparam int POS_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = (NUM_ENCODERS * QUEUE_DEPTH > 1) ?
                          $clog2(NUM_ENCODERS * QUEUE_DEPTH) : 1;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(60);
  localparam logic [IN_USE_W-1:0]   IN_USE_RESET   = IN_USE_W'(5);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENCODERS_IN_USE = CFG_IDX_W'(1);

  // Item operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIN_W-1:0] pins_a;
    logic [PIN_W-1:0] pins_b;
    logic [IDX_W-1:0] encoder_index;
  } item_t;

  typedef struct packed {
    logic             event_valid;
    logic             turn_direction;
    logic [PIN_W-1:0] pending_mask;
    logic             overflow;
  } result_t;

endpackage

// ===== hw/rtl/reeq_if.sv =====
// ----------------------------------------------------------------------------
// reeq_if
// Valid/ready channels carrying input items and result words.
// ----------------------------------------------------------------------------
interface reeq_item_if;
  import reeq_pkg::*;

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface reeq_result_if;
  import reeq_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/rotary_encoder_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_event_queue_core
// Quadrature direction decoder with debounce lockout and one event queue
// per encoder, all queues held in one synchronous event memory.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake        word
//   item_i    in    valid / ready    op, pins_a, pins_b, encoder_index
//   result_o  out   valid / ready    event_valid, turn_direction,
//                                    pending_mask, overflow
//   cfg       in    cfg_we_i         cfg_idx_i, cfg_wdata_i (no read-back)
//
// A sample word with no accepted edge, or a pop of an empty queue, goes
// from accept straight to S_OUT, which moves its result into the output
// register. A pop that returns an event passes through S_POPRD first for
// the event memory read, a sample with accepted edges through S_PUSH: the
// push sequencer visits every encoder once and writes the event memory for
// each edge whose queue has room. The next word is taken once the result
// has moved into the output register, so a stalled result stalls at most
// one word behind it. Reset clears all pointers and fill counts at once;
// the event memory itself is never cleared and needs no clearing pass.
//
`include "assert_macros.svh"

module rotary_encoder_event_queue_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  reeq_item_if.sink                              item_i,
  reeq_result_if.source                          result_o,
  input  logic                                   cfg_we_i,
  input  logic [reeq_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [reeq_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import reeq_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PUSH  = 2'd1;
  localparam logic [1:0] S_POPRD = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos);
    next_pos = (pos == POS_W'(QUEUE_DEPTH - 1)) ? '0 : pos + POS_W'(1);
  endfunction

  // Configuration
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [IN_USE_W-1:0]   in_use_q;

  // Control state
  logic [1:0]            state_q, state_d;
  logic [ENC_W-1:0]      scan_q;
  logic [PIN_W-1:0]      push_mask_q;
  logic [PIN_W-1:0]      push_dir_q;
  logic                  ovf_q;
  logic                  evt_valid_q;
  logic [PIN_W-1:0]      prev_b_q;
  logic [DEBOUNCE_W-1:0] lock_q;
  logic [POS_W-1:0]      wp_q   [NUM_ENCODERS];
  logic [POS_W-1:0]      rp_q   [NUM_ENCODERS];
  logic [CNT_W-1:0]      fill_q [NUM_ENCODERS];

  // Event memory: one queue of QUEUE_DEPTH entries per encoder
  logic                  event_mem_q [NUM_ENCODERS * QUEUE_DEPTH];
  logic                  rd_data_q;

  // Output register
  logic                  out_valid_q;
  result_t               out_q;

  // Combinational helpers
  logic                  item_fire;
  logic [PIN_W-1:0]      en_mask;
  logic [PIN_W-1:0]      edges;
  logic [ENC_W-1:0]      pop_sel;
  logic                  pop_hit;
  logic                  push_now;
  logic                  queue_full;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic                  out_free;
  logic [PIN_W-1:0]      pending;

  assign item_i.ready     = (state_q == S_IDLE);
  assign item_fire        = item_i.valid && item_i.ready;
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;
  assign out_free         = !out_valid_q || result_o.ready;

  // Edge detect: B falling on an enabled encoder
  always_comb begin
    for (int i = 0; i < PIN_W; i++) begin
      en_mask[i] = (i < NUM_ENCODERS) && (i < int'(in_use_q));
    end
    edges = prev_b_q & ~item_i.payload.pins_b & en_mask;
  end

  // Pop lookup
  assign pop_sel = ENC_W'(item_i.payload.encoder_index);
  assign pop_hit = (int'(item_i.payload.encoder_index) < NUM_ENCODERS) &&
                   (fill_q[pop_sel] != '0);
  assign mem_re  = item_fire && (item_i.payload.op == OP_POP) && pop_hit;
  assign mem_raddr = ADDR_W'(pop_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rp_q[pop_sel]);

  // Push sequencer: one encoder per cycle
  assign push_now   = (state_q == S_PUSH) && push_mask_q[scan_q];
  assign queue_full = (fill_q[scan_q] == CNT_W'(QUEUE_DEPTH));
  assign mem_we     = push_now && !queue_full;
  assign mem_waddr  = ADDR_W'(scan_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wp_q[scan_q]);

  always_comb begin
    pending = '0;
    for (int i = 0; i < PIN_W; i++) begin
      if (i < NUM_ENCODERS) begin
        pending[i] = (fill_q[i] != '0);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (item_fire) begin
          if (item_i.payload.op == OP_POP) begin
            state_d = pop_hit ? S_POPRD : S_OUT;
          end else if ((lock_q == '0) && (edges != '0)) begin
            state_d = S_PUSH;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_PUSH: begin
        if (scan_q == ENC_W'(NUM_ENCODERS - 1)) begin
          state_d = S_OUT;
        end
      end
      S_POPRD: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Event memory: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      event_mem_q[mem_waddr] <= push_dir_q[scan_q];
    end
    if (mem_re) begin
      rd_data_q <= event_mem_q[mem_raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      in_use_q   <= IN_USE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE_TICKS:  debounce_q <= cfg_wdata_i[DEBOUNCE_W-1:0];
        REG_ENCODERS_IN_USE: in_use_q   <= cfg_wdata_i[IN_USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Control path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      push_mask_q <= '0;
      push_dir_q  <= '0;
      ovf_q       <= 1'b0;
      evt_valid_q <= 1'b0;
      prev_b_q    <= '1;
      lock_q      <= DEBOUNCE_RESET;
      out_valid_q <= 1'b0;
      for (int e = 0; e < NUM_ENCODERS; e++) begin
        wp_q[e]   <= '0;
        rp_q[e]   <= '0;
        fill_q[e] <= '0;
      end
    end else begin
      state_q <= state_d;

      // Hand the finished word to the output register, else drop the
      // output word once taken
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (item_fire) begin
        scan_q <= '0;
        ovf_q  <= 1'b0;
        if (item_i.payload.op == OP_POP) begin
          evt_valid_q <= pop_hit;
          push_mask_q <= '0;
          if (pop_hit) begin
            rp_q[pop_sel]   <= next_pos(rp_q[pop_sel]);
            fill_q[pop_sel] <= fill_q[pop_sel] - CNT_W'(1);
          end
        end else begin
          evt_valid_q <= 1'b0;
          prev_b_q    <= item_i.payload.pins_b;
          push_dir_q  <= item_i.payload.pins_a;
          if ((lock_q == '0) && (edges != '0)) begin
            // Accepted edge: reload the lockout and queue every edge
            push_mask_q <= edges;
            lock_q      <= debounce_q;
          end else begin
            push_mask_q <= '0;
            if (lock_q != '0) begin
              lock_q <= lock_q - DEBOUNCE_W'(1);
            end
          end
        end
      end

      if (state_q == S_PUSH) begin
        scan_q <= scan_q + ENC_W'(1);
        if (push_now) begin
          if (queue_full) begin
            ovf_q <= 1'b1;
          end else begin
            wp_q[scan_q]   <= next_pos(wp_q[scan_q]);
            fill_q[scan_q] <= fill_q[scan_q] + CNT_W'(1);
          end
        end
      end
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_q.event_valid    <= evt_valid_q;
      out_q.turn_direction <= evt_valid_q & rd_data_q;
      out_q.pending_mask   <= pending;
      out_q.overflow       <= ovf_q;
    end
  end

  // Assertions
  `REEQ_ASSERT(pop_hit_reads,
    (item_fire && (item_i.payload.op == OP_POP) && pop_hit) |=> (state_q == S_POPRD),
    "pop of a non-empty queue did not start a memory read")

  `REEQ_ASSERT_NEVER(pop_has_overflow,
    out_valid_q && out_q.event_valid && out_q.overflow,
    "popped event word carries an overflow flag")

  `REEQ_ASSERT(lockout_counts_down,
    (item_fire && (item_i.payload.op == OP_SAMPLE) && (lock_q != '0))
      |=> (lock_q == $past(lock_q) - DEBOUNCE_W'(1)),
    "lockout did not count down on a sample")

  for (genvar g = 0; g < NUM_ENCODERS; g++) begin : g_fill_chk
    `REEQ_ASSERT_NEVER(fill_bound,
      fill_q[g] > CNT_W'(QUEUE_DEPTH),
      "queue fill count above queue depth")
  end

endmodule

// ===== dv/reeq_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reeq_event_checker
// Watches the item, result and register ports of the encoder event queue,
// keeps its own copy of the decoder and queue state, works out the result
// word for every accepted item word and compares it with the block's output.
// ----------------------------------------------------------------------------
module reeq_event_checker
  import reeq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  reeq_item_if                  item_i,
  reeq_result_if                result_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           awaited_o,
  output int unsigned           words_checked_o,
  output int unsigned           turns_popped_o,
  output int unsigned           overflows_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [IN_USE_W-1:0]   in_use_q;
  logic [PIN_W-1:0]      prev_b_q;
  logic [DEBOUNCE_W-1:0] lockout_q;
  logic                  turn_mem [NUM_ENCODERS][QUEUE_DEPTH];
  int unsigned           head_q   [NUM_ENCODERS];
  int unsigned           fill_q   [NUM_ENCODERS];
  result_t               awaited_words[$];

  // Advance the decoder and queue copy by one item word, return its result.
  function automatic result_t predict_result(input item_t w);
    result_t          r;
    logic [PIN_W-1:0] falls;
    int unsigned      live;
    int unsigned      sel;
    bit               took;
    r    = '0;
    took = 1'b0;
    if (w.op == OP_SAMPLE) begin
      live  = (in_use_q > NUM_ENCODERS) ? NUM_ENCODERS : int'(in_use_q);
      falls = prev_b_q & ~w.pins_b;
      if (lockout_q == '0) begin
        for (int e = 0; e < NUM_ENCODERS && e < PIN_W; e++) begin
          if (e < live && falls[e]) begin
            took = 1'b1;
            if (fill_q[e] >= QUEUE_DEPTH) begin
              r.overflow = 1'b1;
            end else begin
              turn_mem[e][(head_q[e] + fill_q[e]) % QUEUE_DEPTH] = w.pins_a[e];
              fill_q[e]++;
            end
          end
        end
      end
      if (took) begin
        lockout_q = debounce_q;
      end else if (lockout_q != '0) begin
        lockout_q = lockout_q - 1'b1;
      end
      prev_b_q = w.pins_b;
    end else begin
      sel = w.encoder_index;
      if (sel < NUM_ENCODERS && fill_q[sel] != 0) begin
        r.event_valid    = 1'b1;
        r.turn_direction = turn_mem[sel][head_q[sel]];
        head_q[sel]      = (head_q[sel] + 1) % QUEUE_DEPTH;
        fill_q[sel]--;
      end
    end
    for (int e = 0; e < NUM_ENCODERS && e < PIN_W; e++) begin
      r.pending_mask[e] = (fill_q[e] != 0);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, what);
      $display("  expected valid=%0b dir=%0b pending=%05b overflow=%0b",
               want.event_valid, want.turn_direction, want.pending_mask, want.overflow);
      $display("  actual   valid=%0b dir=%0b pending=%05b overflow=%0b",
               got.event_valid, got.turn_direction, got.pending_mask, got.overflow);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    words_checked_o++;
    if (got.event_valid === 1'b1) turns_popped_o++;
    if (got.overflow === 1'b1) overflows_o++;
    if (awaited_words.size() == 0) begin
      report_mismatch("result word with nothing awaited", '0, got);
      return;
    end
    want = awaited_words.pop_front();
    if (got.event_valid !== want.event_valid || got.turn_direction !== want.turn_direction ||
        got.pending_mask !== want.pending_mask || got.overflow !== want.overflow) begin
      report_mismatch("result word mismatch", want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q = DEBOUNCE_RESET;
      in_use_q   = IN_USE_RESET;
      prev_b_q   = '1;
      lockout_q  = DEBOUNCE_RESET;
      for (int e = 0; e < NUM_ENCODERS; e++) begin
        head_q[e] = 0;
        fill_q[e] = 0;
      end
      awaited_words.delete();
      mismatch_count_o = 0;
      awaited_o        = 0;
      words_checked_o  = 0;
      turns_popped_o   = 0;
      overflows_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE_TICKS:  debounce_q = cfg_wdata_i[DEBOUNCE_W-1:0];
          REG_ENCODERS_IN_USE: in_use_q   = cfg_wdata_i[IN_USE_W-1:0];
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        awaited_words.push_back(predict_result(item_i.payload));
      end
      if (result_i.valid && result_i.ready) begin
        check_result(result_i.payload);
      end
      awaited_o = awaited_words.size();
    end
  end

endmodule

// ===== dv/tb_rotary_encoder_event_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_encoder_event_queue_core
// Drives pin samples and pops into the encoder event queue under a series of
// debounce and channel-count settings, with random idling on both channels,
// and lets the checker beside the block compare every result word.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_event_queue_core;
  import reeq_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int LONG_HOLD     = 400;   // cycles of the long result stall
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 220;
  localparam int TAIL_CYCLES   = 2 * NUM_ENCODERS + 8;
  localparam int TIMEOUT_NS    = 12_000_000;

  // Idle modes: which side inserts gaps and stalls.
  localparam int MODE_NONE     = 0;
  localparam int MODE_SENDER   = 1;
  localparam int MODE_RECEIVER = 2;
  localparam int MODE_BOTH     = 3;

  // Register settings per random phase. The huge debounce comes last: once
  // it is loaded the lockout outlives the rest of the run.
  int unsigned debounce_plan [PHASES] = '{0, 1, 0, 2, 0, 3, 0, 65535};
  int unsigned in_use_plan   [PHASES] = '{5, 3, 7, 0, 1, 6, 4, 5};
  int unsigned mode_plan     [PHASES] = '{MODE_NONE, MODE_SENDER, MODE_RECEIVER, MODE_BOTH,
                                          MODE_NONE, MODE_SENDER, MODE_RECEIVER, MODE_BOTH};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  reeq_item_if   item_bus();
  reeq_result_if result_bus();

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned words_checked;
  int unsigned turns_popped;
  int unsigned overflows_seen;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_requests;     // bumped to ask the receiver for a long stall
  int unsigned words_sent;
  int unsigned settings_used;

  rotary_encoder_event_queue_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  reeq_event_checker turn_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_bus),
    .result_i         (result_bus),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .awaited_o        (awaited),
    .words_checked_o  (words_checked),
    .turns_popped_o   (turns_popped),
    .overflows_o      (overflows_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #TIMEOUT_NS;
    $display("tb_rotary_encoder_event_queue_core failed");
    $finish;
  end

  // Result side: drive ready at every falling edge. A long hold, when asked
  // for, is counted down here while the sender keeps offering words, so the
  // block fills its output register and stops taking items.
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left         = 0;
    holds_served      = 0;
    result_bus.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        hold_left    = LONG_HOLD;
        holds_served = hold_requests;
      end
      if (hold_left != 0) begin
        result_bus.ready = 1'b0;
        hold_left--;
      end else begin
        result_bus.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  function automatic item_t make_word(input logic op, input logic [PIN_W-1:0] a,
                                      input logic [PIN_W-1:0] b,
                                      input logic [IDX_W-1:0] idx);
    item_t w;
    w.op            = op;
    w.pins_a        = a;
    w.pins_b        = b;
    w.encoder_index = idx;
    return w;
  endfunction

  // Offer one word and hold it until accepted. Called just after a falling
  // edge, returns just after the falling edge that follows the accept, and
  // leaves valid high so that the next word follows without a gap.
  task automatic send_word(input item_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid   = 1'b1;
    item_bus.payload = w;
    do @(posedge clk_i); while (!item_bus.ready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic tick(input logic [PIN_W-1:0] a, input logic [PIN_W-1:0] b);
    send_word(make_word(OP_SAMPLE, a, b, IDX_W'($urandom)));
  endtask

  task automatic pop_queue(input logic [IDX_W-1:0] idx);
    send_word(make_word(OP_POP, PIN_W'($urandom), PIN_W'($urandom), idx));
  endtask

  // Raise B on the masked encoders, then drop it: one falling edge each.
  task automatic turn_pair(input logic [PIN_W-1:0] fall_mask);
    tick(PIN_W'($urandom), PIN_W'($urandom) | fall_mask);
    tick(PIN_W'($urandom), PIN_W'($urandom) & ~fall_mask);
  endtask

  // Drop valid and wait until every word sent has come back.
  task automatic settle();
    item_bus.valid = 1'b0;
    while (awaited != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_setting(input int unsigned debounce, input int unsigned in_use);
    settle();
    write_reg(REG_DEBOUNCE_TICKS, CFG_DATA_W'(debounce));
    write_reg(REG_ENCODERS_IN_USE, CFG_DATA_W'(in_use));
    settings_used++;
  endtask

  task automatic set_mode(input int unsigned mode);
    case (mode)
      MODE_SENDER:   begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
      MODE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
      MODE_BOTH:     begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
    endcase
  endtask

  // Mostly well-formed turns and pops with random content, some runs long
  // enough to overflow a queue, and a share of raw noise words.
  task automatic random_traffic(input int unsigned count);
    int unsigned      stop_at;
    int unsigned      kind;
    logic [PIN_W-1:0] mask;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        repeat ($urandom_range(6, 1)) turn_pair(PIN_W'($urandom_range(31, 1)));
      end else if (kind < 52) begin
        mask = PIN_W'($urandom_range(31, 1));
        repeat (QUEUE_DEPTH + 1) turn_pair(mask);
      end else if (kind < 85) begin
        repeat ($urandom_range(24, 1)) begin
          if ($urandom_range(99) < 85) pop_queue(IDX_W'($urandom_range(NUM_ENCODERS - 1)));
          else pop_queue(IDX_W'($urandom));
        end
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_word(make_word(1'($urandom), PIN_W'($urandom), PIN_W'($urandom),
                              IDX_W'($urandom)));
        end
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    item_bus.valid     = 1'b0;
    item_bus.payload   = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests      = 0;
    words_sent         = 0;
    settings_used      = 1;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Pops of an empty queue and of encoder numbers that do not exist.
    pop_queue(IDX_W'(0));
    pop_queue(IDX_W'(NUM_ENCODERS));
    pop_queue('1);

    // The reset lockout swallows every edge until it has run down.
    repeat (int'(DEBOUNCE_RESET) / 2) turn_pair('1);

    // First accepted edge: right turns on the even encoders, left on the odd.
    tick('0, '1);
    tick(5'b10101, '0);
    pop_queue(IDX_W'(0));
    pop_queue(IDX_W'(1));

    // Two channels only: the reloaded lockout must run down first, then an
    // edge on every pin queues events for encoders 0 and 1 alone. Encoder 3
    // is disabled now but still drains what it queued earlier.
    apply_setting(0, 2);
    repeat (int'(DEBOUNCE_RESET)) tick(PIN_W'($urandom), PIN_W'($urandom));
    turn_pair('1);
    pop_queue(IDX_W'(3));

    // Channel count above the encoder count: all five take events, until
    // the queues are full and the extra edge raises overflow.
    apply_setting(0, 7);
    repeat (QUEUE_DEPTH + 1) turn_pair('1);

    // Random phases across the register settings and idle modes. Phases that
    // stall only the receiver also get one long hold-off to back up the input.
    for (int p = 0; p < PHASES; p++) begin
      apply_setting(debounce_plan[p], in_use_plan[p]);
      set_mode(mode_plan[p]);
      if (mode_plan[p] == MODE_RECEIVER) hold_requests++;
      random_traffic(PHASE_WORDS);
    end

    // Drain, then give the pipeline time to show any stray word.
    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d item words over %0d register settings, idling on neither, either",
             words_sent, settings_used);
    $display("and both sides; checked %0d result words, %0d turn events, %0d overflows.",
             words_checked, turns_popped, overflows_seen);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb_rotary_encoder_event_queue_core passed");
    end else begin
      $display("tb_rotary_encoder_event_queue_core failed");
    end
    $finish;
  end

endmodule
